/* hdl/tcts_pkg.sv */
package tcts_pkg;

   // Command codes carried in each request beat.
   localparam logic [1:0] CMD_STAMP = 2'd0;
   localparam logic [1:0] CMD_BASE  = 2'd1;
   localparam logic [1:0] CMD_CALIB = 2'd2;

   // Fine counter operating modes.
   localparam logic [1:0] MODE_RATE   = 2'd2;
   localparam logic [1:0] MODE_SQUARE = 2'd3;

   // Calibration run length and the width of its counter.
   localparam int MATCH_RUN_W = 7;
   localparam logic [MATCH_RUN_W-1:0] CALIB_MATCHES = 7'd64;

   // Coarse ticks in one day and the Q0.32 reciprocal scale factors.
   localparam logic [21:0] TICKS_DAY = 22'd1573040;
   localparam logic [31:0] R_US      = 32'd3599597124;
   localparam logic [31:0] R_MS      = 32'd3685987455;

   // Request beat payload.
   typedef struct packed {
      logic [1:0]  cmd;
      logic [20:0] day_ticks;
      logic [15:0] fine_count;
      logic        fine_out_level;
      logic [4:0]  helper_count;
   } req_type;

   // Response beat payload.
   typedef struct packed {
      logic        in_sync;
      logic        calibrated;
      logic [31:0] micro_time;
      logic [31:0] milli_time;
   } rsp_type;

   // Normalized fine count, derived phase and coarse count mod 9.
   typedef struct packed {
      logic [15:0] fine;
      logic [3:0]  phase;
      logic [3:0]  day_mod9;
   } norm_type;

   // Operands for the timestamp stages, after tick correction.
   typedef struct packed {
      logic [21:0] tick;
      logic [21:0] base_tick;
      logic [15:0] fine;
      logic [11:0] base_fine_hi;
      logic        in_sync;
      logic        calibrated;
   } stamp_type;

   // Load enables for the back stages of the pipeline.
   typedef struct packed {
      logic c_load;
      logic d_load;
   } pipe_ctl_type;

   // Residue mod 9 of a value up to 22 bits. Since 64 is 1 mod 9 the
   // 6-bit chunks are summed, folded once more, then reduced by a
   // priority pick over the multiples of 9.
   function automatic logic [3:0] mod9(input logic [21:0] x);
      logic [7:0] s1;
      logic [6:0] s2;
      logic [6:0] r;
      s1 = 8'(x[5:0]) + 8'(x[11:6]) + 8'(x[17:12]) + 8'(x[21:18]);
      s2 = 7'(s1[7:6]) + 7'(s1[5:0]);
      r  = s2;
      for (int k = 1; k <= 7; k++) begin
         if (s2 >= 7'(9 * k)) begin
            r = s2 - 7'(9 * k);
         end
      end
      return r[3:0];
   endfunction

endpackage

/* hdl/tcts_norm.sv */
module tcts_norm (
   input  logic [1:0]       counter_mode,
   input  tcts_pkg::req_type req,
   output tcts_pkg::norm_type norm
);

   logic [15:0] c_half;
   logic [15:0] fine;
   logic [3:0]  fine_mod9;
   logic [4:0]  fine_mod18;
   logic [6:0]  d_raw;
   logic [6:0]  d_val;

   // Turn the raw down-count into an up-count for the active mode.
   always_comb begin
      c_half = {1'b0, req.fine_count[15:1]} - 16'd1;
      c_half[15] = c_half[15] | req.fine_out_level;
      if (counter_mode == tcts_pkg::MODE_RATE) begin
         fine = ~(req.fine_count - 16'd1);
      end else if (req.fine_count == 16'd0) begin
         fine = req.fine_out_level ? 16'h0000 : 16'h8000;
      end else begin
         fine = ~c_half;
      end
   end

   // Fine count mod 18 from its residue mod 9 and its parity.
   always_comb begin
      fine_mod9 = tcts_pkg::mod9({6'd0, fine});
      if (fine_mod9[0] == fine[0]) begin
         fine_mod18 = {1'b0, fine_mod9};
      end else begin
         fine_mod18 = {1'b0, fine_mod9} + 5'd9;
      end
   end

   // Helper phase offset; the difference always lies in 6..54.
   always_comb begin
      d_raw = 7'd54 - {2'd0, req.helper_count} - {2'd0, fine_mod18};
      if (d_raw >= 7'd54) begin
         d_val = d_raw - 7'd54;
      end else if (d_raw >= 7'd36) begin
         d_val = d_raw - 7'd36;
      end else if (d_raw >= 7'd18) begin
         d_val = d_raw - 7'd18;
      end else begin
         d_val = d_raw;
      end
   end

   assign norm.fine     = fine;
   assign norm.phase    = 4'd8 - d_val[4:1];
   assign norm.day_mod9 = tcts_pkg::mod9({1'b0, req.day_ticks});

endmodule

/* hdl/tcts_scale.sv */
module tcts_scale (
   input  logic                   clock,
   input  tcts_pkg::pipe_ctl_type ctl,
   input  tcts_pkg::stamp_type    stamp,
   output tcts_pkg::rsp_type      rsp_data
);

   logic [31:0] t_diff;
   logic [31:0] us_in;
   logic [31:0] ms_in;
   logic [31:0] us_ff;
   logic [31:0] ms_ff;
   logic        sync_ff;
   logic        cal_ff;
   logic [63:0] us_prod;
   logic [63:0] ms_prod;
   tcts_pkg::rsp_type rsp_ff;

   // Elapsed ticks and the fixed-point time words before scaling.
   always_comb begin
      t_diff = {10'd0, stamp.tick} - {10'd0, stamp.base_tick};
      us_in  = {t_diff[19:0], stamp.fine[15:4]} - {20'd0, stamp.base_fine_hi};
      ms_in  = {t_diff[25:0], stamp.fine[15:10]} + {31'd0, stamp.fine[9]};
   end

   always_ff @(posedge clock) begin
      if (ctl.c_load) begin
         us_ff   <= us_in;
         ms_ff   <= ms_in;
         sync_ff <= stamp.in_sync;
         cal_ff  <= stamp.calibrated;
      end
   end

   // Reciprocal multiplies; the upper word of each product is the result.
   assign us_prod = {32'd0, us_ff} * {32'd0, tcts_pkg::R_US};
   assign ms_prod = {32'd0, ms_ff} * {32'd0, tcts_pkg::R_MS};

   always_ff @(posedge clock) begin
      if (ctl.d_load) begin
         rsp_ff.in_sync    <= sync_ff;
         rsp_ff.calibrated <= cal_ff;
         rsp_ff.micro_time <= us_prod[63:32];
         rsp_ff.milli_time <= ms_prod[63:32];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

/* hdl/tick_counter_timestamp_sync.sv */
// Channel  Direction  Ports                         Beat payload
// req      in         req_valid req_stall req_data  tcts_pkg::req_type
// rsp      out        rsp_valid rsp_stall rsp_data  tcts_pkg::rsp_type
// csr      in         csr_wr_en csr_wr_data         counter_mode, 2 bits
//
// One request beat is taken every cycle unless req_stall is raised; its response
// beat passes through four register stages: normalize, tick correction with the
// state update, time words, reciprocal multiply.
// Synchronous active-high reset empties the pipeline, clears the sync
// state and sets counter_mode to square wave.
// A stalled response holds its stage; earlier stages keep filling until
// the pipeline is full, and only then is req_stall raised.
module tick_counter_timestamp_sync (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tcts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tcts_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_wr_data
);

   typedef struct packed {
      logic [1:0]  cmd;
      logic [20:0] day;
      logic [15:0] fine;
      logic [3:0]  phase;
      logic [3:0]  day_mod9;
   } front_type;

   logic [1:0]  counter_mode_ff;
   logic        v0_ff, v1_ff, v2_ff, v3_ff;
   logic        e0, e1, e2, e3;
   logic        b_load;
   tcts_pkg::norm_type  norm;
   front_type           a_ff;
   tcts_pkg::stamp_type stamp_ff;
   tcts_pkg::stamp_type stamp_in;
   tcts_pkg::pipe_ctl_type ctl;

   logic [20:0] last_tick_ff;
   logic [21:0] base_tick_ff;
   logic [15:0] base_fine_ff;
   logic [3:0]  phase_ref_ff;
   logic [tcts_pkg::MATCH_RUN_W-1:0] match_run_ff;
   logic [tcts_pkg::MATCH_RUN_W-1:0] match_run_in;

   logic        is_base;
   logic [20:0] eff_last;
   logic        roll;
   logic [3:0]  tick_mod9;
   logic [4:0]  diff_sum;
   logic [3:0]  diff;
   logic [3:0]  diff_next;
   logic        match;
   logic        lag;
   logic [21:0] tick;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         counter_mode_ff <= tcts_pkg::MODE_SQUARE;
      end else if (csr_wr_en) begin
         counter_mode_ff <= csr_wr_data;
      end
   end

   // Stage enables: a stage loads when it is empty or its successor loads.
   assign e3 = !v3_ff || !rsp_stall;
   assign e2 = !v2_ff || e3;
   assign e1 = !v1_ff || e2;
   assign e0 = !v0_ff || e1;
   assign b_load = v0_ff && e1;
   assign ctl.c_load = v1_ff && e2;
   assign ctl.d_load = v2_ff && e3;
   assign req_stall = !e0;
   assign rsp_valid = v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (e0) v0_ff <= req_valid;
         if (e1) v1_ff <= v0_ff;
         if (e2) v2_ff <= v1_ff;
         if (e3) v3_ff <= v2_ff;
      end
   end

   // Front stage: normalize the fine count and derive the phase.
   tcts_norm u_norm (
      .counter_mode (counter_mode_ff),
      .req          (req_data),
      .norm         (norm)
   );

   always_ff @(posedge clock) begin
      if (e0 && req_valid) begin
         a_ff.cmd      <= req_data.cmd;
         a_ff.day      <= req_data.day_ticks;
         a_ff.fine     <= norm.fine;
         a_ff.phase    <= norm.phase;
         a_ff.day_mod9 <= norm.day_mod9;
      end
   end

   // Rollover, phase compare and lagging-tick correction.
   always_comb begin
      is_base  = (a_ff.cmd == tcts_pkg::CMD_BASE);
      eff_last = is_base ? 21'd0 : last_tick_ff;
      roll     = (a_ff.day < eff_last);
      if (!roll) begin
         tick_mod9 = a_ff.day_mod9;
      end else if (a_ff.day_mod9 >= 4'd7) begin
         tick_mod9 = a_ff.day_mod9 - 4'd7;
      end else begin
         tick_mod9 = a_ff.day_mod9 + 4'd2;
      end
      diff_sum  = 5'd9 + {1'b0, tick_mod9} - {1'b0, a_ff.phase};
      diff      = (diff_sum >= 5'd9) ? 4'(diff_sum - 5'd9) : diff_sum[3:0];
      diff_next = (diff == 4'd8) ? 4'd0 : diff + 4'd1;
      match     = (diff == phase_ref_ff);
      lag       = !match && (diff_next == phase_ref_ff);
      tick      = {1'b0, a_ff.day} + (roll ? tcts_pkg::TICKS_DAY : 22'd0)
                  + {21'd0, lag};
   end

   // Calibration run count.
   always_comb begin
      match_run_in = match_run_ff;
      if (a_ff.cmd == tcts_pkg::CMD_CALIB) begin
         if (!match) begin
            match_run_in = '0;
         end else if (match_run_ff < tcts_pkg::CALIB_MATCHES) begin
            match_run_in = match_run_ff + {{(tcts_pkg::MATCH_RUN_W-1){1'b0}}, 1'b1};
         end
      end
   end

   always_comb begin
      stamp_in.tick         = tick;
      stamp_in.base_tick    = is_base ? tick : base_tick_ff;
      stamp_in.fine         = a_ff.fine;
      stamp_in.base_fine_hi = is_base ? a_ff.fine[15:4] : base_fine_ff[15:4];
      stamp_in.in_sync      = match || lag;
      stamp_in.calibrated   = (match_run_in >= tcts_pkg::CALIB_MATCHES);
   end

   // Sync state advances as each beat leaves the front stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_tick_ff <= '0;
         base_tick_ff <= '0;
         base_fine_ff <= '0;
         phase_ref_ff <= '0;
         match_run_ff <= '0;
      end else if (b_load) begin
         last_tick_ff <= a_ff.day;
         match_run_ff <= match_run_in;
         if (is_base) begin
            base_tick_ff <= tick;
            base_fine_ff <= a_ff.fine;
         end
         if (a_ff.cmd == tcts_pkg::CMD_CALIB) begin
            phase_ref_ff <= diff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_load) begin
         stamp_ff <= stamp_in;
      end
   end

   // Time words and reciprocal scaling.
   tcts_scale u_scale (
      .clock    (clock),
      .ctl      (ctl),
      .stamp    (stamp_ff),
      .rsp_data (rsp_data)
   );

   // The run counter never passes its saturation point.
   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      match_run_ff <= tcts_pkg::CALIB_MATCHES)
      else $error("match run above saturation");

   // An accepted beat always occupies the front stage next cycle.
   a_accept_fill: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> v0_ff)
      else $error("accepted beat lost");

   // A front stage that cannot move on holds its contents.
   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      v0_ff && !e1 |=> $stable(a_ff) && v0_ff)
      else $error("front stage changed while blocked");

   // The rollover reference follows the coarse count of each beat.
   a_last_tick: assert property (@(posedge clock) disable iff (reset)
      b_load |=> last_tick_ff == $past(a_ff.day))
      else $error("last tick not updated");

   // A baseline capture stores the tick it hands on.
   a_base_tick: assert property (@(posedge clock) disable iff (reset)
      b_load && is_base |=> base_tick_ff == stamp_ff.tick)
      else $error("baseline tick mismatch");

endmodule

/* sim/tcts_checker.sv */
// Watches both channels and the mode register of the timestamp synchronizer,
// predicts every response beat from the accepted request beats and compares
// the two field by field.
module tcts_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  tcts_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  tcts_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_wr_data,
   output int                mismatch_count,
   output int                queued_beats
);

   import tcts_pkg::*;

   // Shadow copy of the mode register and the synchronizer state.
   logic [1:0]             fine_mode;
   logic [20:0]            last_day;
   logic [21:0]            origin_tick;
   logic [15:0]            origin_fine;
   logic [3:0]             ref_phase;
   logic [MATCH_RUN_W-1:0] equal_run;

   // Timestamps still owed by the block, oldest first.
   rsp_type expected_stamps[$];

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      end
   endtask

   // Computes the timestamp for one snapshot and advances the shadow state.
   function automatic rsp_type predict_timestamp(input req_type r);
      logic [15:0] down;
      logic [15:0] fine;
      int unsigned rem;
      int unsigned phase;
      int unsigned diff;
      logic [31:0] tick;
      logic [31:0] elapsed;
      logic [31:0] us_word;
      logic [31:0] ms_word;
      logic [63:0] us_prod;
      logic [63:0] ms_prod;
      rsp_type     stamp;

      // A baseline capture forgets the previous coarse count.
      if (r.cmd == CMD_BASE) begin
         last_day = '0;
      end

      // Turn the raw down-count into an up-count; unused modes count as square wave.
      if (fine_mode == MODE_RATE) begin
         down = r.fine_count - 16'd1;
      end else if (r.fine_count == 16'd0) begin
         down = r.fine_out_level ? 16'hFFFF : 16'h7FFF;
      end else begin
         down = (r.fine_count >> 1) - 16'd1;
         if (r.fine_out_level) begin
            down[15] = 1'b1;
         end
      end
      fine = 16'hFFFF - down;

      // Phase from the fine and helper counters, then its offset from the coarse count.
      rem   = (54 - r.helper_count - fine % 18) % 18;
      phase = 8 - (rem >> 1);

      // A coarse count that went backwards has passed midnight.
      tick = 32'(r.day_ticks);
      if (r.day_ticks < last_day) begin
         tick = tick + 32'(TICKS_DAY);
      end
      last_day = r.day_ticks;

      diff = (9 + tick % 9 - phase) % 9;

      // A tick that lags the reference by one phase is pulled forward.
      if (diff == ref_phase) begin
         stamp.in_sync = 1'b1;
      end else if ((diff + 1) % 9 == ref_phase) begin
         tick          = tick + 32'd1;
         stamp.in_sync = 1'b1;
      end else begin
         stamp.in_sync = 1'b0;
      end

      // Baseline capture or calibration bookkeeping.
      if (r.cmd == CMD_BASE) begin
         origin_tick = tick[21:0];
         origin_fine = fine;
      end else if (r.cmd == CMD_CALIB) begin
         if (diff == ref_phase) begin
            if (equal_run < CALIB_MATCHES) begin
               equal_run = equal_run + {{(MATCH_RUN_W-1){1'b0}}, 1'b1};
            end
         end else begin
            equal_run = '0;
         end
         ref_phase = diff[3:0];
      end
      stamp.calibrated = (equal_run >= CALIB_MATCHES);

      // Time words relative to the baseline, scaled by the Q0.32 reciprocals.
      elapsed = tick - 32'(origin_tick);
      us_word = ((elapsed << 12) | 32'(fine >> 4)) - 32'(origin_fine >> 4);
      ms_word = (elapsed << 6) | 32'(fine >> 10);
      if (fine[9]) begin
         ms_word = ms_word + 32'd1;
      end
      us_prod          = 64'(us_word) * 64'(R_US);
      ms_prod          = 64'(ms_word) * 64'(R_MS);
      stamp.micro_time = us_prod[63:32];
      stamp.milli_time = ms_prod[63:32];
      return stamp;
   endfunction

   // Sample both channels and the register port at each rising edge.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fine_mode   = MODE_SQUARE;
         last_day    = '0;
         origin_tick = '0;
         origin_fine = '0;
         ref_phase   = '0;
         equal_run   = '0;
         expected_stamps.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_stamps.size() == 0) begin
               report_mismatch("response beat with no timestamp outstanding");
            end else begin
               want = expected_stamps.pop_front();
               compare_field("in_sync", 32'(rsp_data.in_sync), 32'(want.in_sync));
               compare_field("calibrated", 32'(rsp_data.calibrated), 32'(want.calibrated));
               compare_field("micro_time", rsp_data.micro_time, want.micro_time);
               compare_field("milli_time", rsp_data.milli_time, want.milli_time);
            end
         end
         if (csr_wr_en) begin
            fine_mode = csr_wr_data;
         end
         if (req_valid && !req_stall) begin
            expected_stamps.push_back(predict_timestamp(req_data));
         end
      end
      queued_beats <= expected_stamps.size();
   end

endmodule

/* sim/tb.sv */
module tb;

   import tcts_pkg::*;

   // Unused command code; the block treats it as a plain timestamp.
   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam int         DAY_MAX   = 2097151;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_data    = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en   = 1'b0;
   logic [1:0] csr_wr_data = MODE_SQUARE;

   int mismatch_count;
   int queued_beats;

   // Sender burst state and receiver stall state.
   int beats_sent  = 0;
   int burst_left  = 4;
   int stall_pct   = 0;
   int stall_timer = 0;

   tick_counter_timestamp_sync dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   tcts_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .queued_beats   (queued_beats)
   );

   always #2 clock = ~clock;

   // The receiver draws a new stall rate each time its timer runs out, sometimes none.
   always @(posedge clock) begin
      if (stall_timer == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 50;
            default: stall_pct = 85;
         endcase
         stall_timer = 50;
      end
      stall_timer = stall_timer - 1;
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Sends one beat and then, at the end of a burst, idles for a random gap.
   task automatic send_beat(input req_type r);
      int gap;
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      beats_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_fields(input logic [1:0] cmd, input int day, input int fine,
                              input logic level, input int helper);
      req_type r;
      r.cmd            = cmd;
      r.day_ticks      = 21'(day);
      r.fine_count     = 16'(fine);
      r.fine_out_level = level;
      r.helper_count   = 5'(helper);
      send_beat(r);
   endtask

   // Holds off the sender until every timestamp is back and the pipeline is empty.
   task automatic wait_idle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (queued_beats != 0 && waited < 20000);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_mode(input logic [1:0] mode);
      csr_wr_data <= mode;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Calibration samples with fixed counters and the coarse count stepping by
   // whole phase cycles, so every sample shows the same phase difference.
   // Now and then one sample is knocked out of step.
   task automatic run_calibration(input int count);
      int   day;
      int   fine;
      int   helper;
      int   broken_at;
      logic level;
      day       = $urandom_range(0, 1500000);
      fine      = $urandom_range(0, 65535);
      helper    = $urandom_range(0, 17);
      level     = 1'($urandom_range(0, 1));
      broken_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, count - 1) : -1;
      for (int k = 0; k < count; k++) begin
         day = day + 9 * $urandom_range(1, 3);
         if (k == broken_at) begin
            send_fields(CMD_CALIB, day + 1, fine, level, helper);
         end else begin
            send_fields(CMD_CALIB, day, fine, level, helper);
         end
      end
   endtask

   // Timestamp samples with a slowly advancing coarse count, often across midnight.
   task automatic run_walk(input int count);
      int day;
      day = $urandom_range(0, 1) ? $urandom_range(0, int'(TICKS_DAY) - 1)
                                 : int'(TICKS_DAY) - 1 - $urandom_range(0, 40);
      for (int k = 0; k < count; k++) begin
         day = day + $urandom_range(0, 3);
         if (day >= int'(TICKS_DAY)) begin
            day = day - int'(TICKS_DAY);
         end
         send_fields(($urandom_range(0, 9) == 0) ? CMD_SPARE : CMD_STAMP, day,
                     $urandom_range(0, 65535), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 17));
      end
   endtask

   task automatic send_noise();
      send_fields(2'($urandom_range(0, 3)), $urandom_range(0, DAY_MAX),
                  $urandom_range(0, 65535), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 31));
   endtask

   // Stimulus: directed corner cases, then random phases under each mode.
   initial begin
      logic [1:0] modes[6];
      int         waited;
      int         phase_end;
      modes = '{MODE_RATE, MODE_SQUARE, 2'd0, MODE_RATE, 2'd1, MODE_SQUARE};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Corner cases under the reset mode: counter extremes, midnight,
      // out-of-range ticks and helper counts, every command.
      send_fields(CMD_STAMP, 0, 0, 1'b0, 0);
      send_fields(CMD_STAMP, 0, 0, 1'b1, 17);
      send_fields(CMD_BASE, int'(TICKS_DAY) - 1, 65535, 1'b1, 18);
      send_fields(CMD_STAMP, 5, 1, 1'b0, 31);
      send_fields(CMD_STAMP, int'(TICKS_DAY), 1, 1'b1, 0);
      send_fields(CMD_CALIB, DAY_MAX - 18, 16'h8000, 1'b1, 1);
      send_fields(CMD_CALIB, DAY_MAX - 9, 16'h8000, 1'b1, 1);
      send_fields(CMD_CALIB, DAY_MAX, 16'h8000, 1'b1, 1);
      send_fields(CMD_SPARE, 1048576, 16'h7FFF, 1'b0, 16);
      send_fields(CMD_BASE, 0, 16'h0200, 1'b0, 9);
      send_fields(CMD_STAMP, 1, 16'h0201, 1'b1, 30);
      send_fields(CMD_CALIB, 100, 2, 1'b0, 19);
      send_fields(CMD_STAMP, 99, 65534, 1'b0, 5);

      foreach (modes[p]) begin
         wait_idle();
         write_mode(modes[p]);
         // Fine counter extremes under the new mode.
         send_fields(CMD_STAMP, $urandom_range(0, DAY_MAX), 0, 1'($urandom_range(0, 1)), 3);
         send_fields(CMD_STAMP, $urandom_range(0, DAY_MAX), 1, 1'($urandom_range(0, 1)), 7);
         send_fields(CMD_STAMP, $urandom_range(0, DAY_MAX), 65535, 1'($urandom_range(0, 1)), 12);
         if (p % 3 == 0) begin
            run_calibration(70);
         end
         phase_end = beats_sent + 25;
         while (beats_sent < phase_end) begin
            case ($urandom_range(0, 9))
               0, 1, 2: run_calibration($urandom_range(0, 1) ? $urandom_range(66, 74)
                                                             : $urandom_range(6, 30));
               3, 4, 5, 6: run_walk($urandom_range(5, 30));
               7: send_fields(CMD_BASE, $urandom_range(0, int'(TICKS_DAY) - 1),
                              $urandom_range(0, 65535), 1'($urandom_range(0, 1)),
                              $urandom_range(0, 17));
               default: send_noise();
            endcase
         end
      end

      // Let the last timestamps drain, then give the verdict.
      req_valid <= 1'b0;
      waited = 0;
      while (queued_beats != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (12) @(posedge clock);
      if (mismatch_count == 0 && queued_beats == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule
